// ===== rtl/nedq_pkg.sv =====
// nedq_pkg: shared types and constants for the note event queue with dedup
// holds the transaction payload structs, operation codes, stored command format
// and sequencer states; no dependencies
`default_nettype none

package nedq_pkg;

   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] NOTE_MAX        = 8'd127;
   localparam logic [7:0] VELOCITY_MAX    = 8'd127;
   localparam int         NOTE_COUNT      = 128;
   localparam int         POP_CHUNK_W     = 8;
   localparam int         POP_CHUNKS      = NOTE_COUNT / POP_CHUNK_W;
   localparam int         CHUNK_IDX_W     = $clog2(POP_CHUNKS);

   typedef enum logic [2:0] {
      OP_NOTE_ON     = 3'd0,
      OP_NOTE_OFF    = 3'd1,
      OP_RENDER      = 3'd2,
      OP_RELEASE_ALL = 3'd3,
      OP_CLEAR       = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  note;
      logic [7:0]  velocity;
      logic [15:0] sample_offset;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        message_valid;
      logic [7:0]  status_byte;
      logic [6:0]  note_out;
      logic [6:0]  velocity_out;
      logic [15:0] event_offset;
      logic [63:0] released_low;
      logic [63:0] released_high;
      logic [7:0]  emitted_count;
      logic        last;
   } rsp_type;

   // one queued command, 15 bits
   typedef struct packed {
      logic       note_on;
      logic [6:0] note;
      logic [6:0] velocity;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_REL_OUT,
      ST_CNT_RD,
      ST_CNT_EV,
      ST_EMIT_RD,
      ST_EMIT_EV
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/note_event_queue_with_dedup_top.sv =====
// note_event_queue_with_dedup_top: ring queue of note commands with a render
// sequencer, held-note map and chunked popcount; uses nedq_pkg and nedq_ring
//
// usage: one request transaction on req_* gives one or more response
// transactions on rsp_*; rsp_payload.last marks the final one of a request.
// enqueue, release-all request, clear and unused codes: one response loaded
// in the cycle the request is taken, so a new request is taken every cycle
// while the response register drains.
// render: a count pass reads each queued command (a read and an evaluate state
// per command) to find the message total, then an emit pass reads them again
// (both states again, plus any response stall) and sends one response per
// message, or one empty response if none. render with release pending: a chunked
// 8-bit popcount over the held map, then one response with both masks.
// the single read port of the command store sets the per-command cost.
// req_ready is low while a render runs and while the response register is
// full and not being taken; a stalled receiver simply holds the sequencer.
// reset (synchronous, active high) empties the queue, clears the pending
// flag and the held map; the command store itself is not cleared.
`default_nettype none

module note_event_queue_with_dedup_top import nedq_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = (PTR_W > 8) ? PTR_W : 8;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(POP_CHUNKS - 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_IDX) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [3:0] popcnt8(input logic [POP_CHUNK_W-1:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < POP_CHUNK_W; i++) begin
         c = c + 4'(v[i]);
      end
      return c;
   endfunction

   state_type state_ff, state_in;
   logic [PTR_W-1:0] rp_ff, rp_in, wp_ff, wp_in, scan_ff, scan_in;
   logic pending_ff, pending_in;
   logic [NOTE_COUNT-1:0] held_ff, held_in, scratch_ff, scratch_in;
   logic [CNT_W-1:0] count_ff, count_in, emit_ff, emit_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [15:0] offset_ff, offset_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0] ram_rd_addr;
   cmd_type ram_wr_data, ram_rd_data;

   logic out_free, rsp_load, full, note_ok, vel_ok;
   logic [PTR_W-1:0] scan_next;

   nedq_ring #(.DEPTH(QUEUE_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign full      = (next_ptr(wp_ff) == rp_ff);
   assign note_ok   = (req_payload.note <= NOTE_MAX);
   assign vel_ok    = (req_payload.velocity != 8'd0) && (req_payload.velocity <= VELOCITY_MAX);
   assign scan_next = next_ptr(scan_ff);

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      scan_in     = scan_ff;
      pending_in  = pending_ff;
      held_in     = held_ff;
      scratch_in  = scratch_ff;
      count_in    = count_ff;
      emit_in     = emit_ff;
      chunk_in    = chunk_ff;
      offset_in   = offset_ff;
      rsp_in      = '0;
      rsp_in.last = 1'b1;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (op_type'(req_payload.operation))
                  OP_NOTE_ON: begin
                     rsp_load = 1'b1;
                     if (note_ok && vel_ok && !full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = '{note_on: 1'b1, note: req_payload.note[6:0],
                                        velocity: req_payload.velocity[6:0]};
                        wp_in           = next_ptr(wp_ff);
                        rsp_in.accepted = 1'b1;
                     end
                  end
                  OP_NOTE_OFF: begin
                     rsp_load = 1'b1;
                     if (note_ok) begin
                        if (!full) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_data = '{note_on: 1'b0, note: req_payload.note[6:0],
                                           velocity: 7'd0};
                           wp_in           = next_ptr(wp_ff);
                           rsp_in.accepted = 1'b1;
                        end else begin
                           pending_in = 1'b1;
                        end
                     end
                  end
                  OP_RENDER: begin
                     offset_in = req_payload.sample_offset;
                     count_in  = '0;
                     if (pending_ff) begin
                        chunk_in = '0;
                        state_in = ST_POP;
                     end else if (rp_ff == wp_ff) begin
                        rsp_load            = 1'b1;
                        rsp_in.event_offset = req_payload.sample_offset;
                     end else begin
                        scratch_in = held_ff;
                        scan_in    = rp_ff;
                        state_in   = ST_CNT_RD;
                     end
                  end
                  OP_RELEASE_ALL: begin
                     rsp_load   = 1'b1;
                     pending_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     rsp_load   = 1'b1;
                     rp_in      = wp_ff;
                     pending_in = 1'b0;
                     held_in    = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            count_in = count_ff + CNT_W'(popcnt8(held_ff[{chunk_ff, 3'b000} +: POP_CHUNK_W]));
            chunk_in = CHUNK_IDX_W'(chunk_ff + 1'b1);
            if (chunk_ff == LAST_CHUNK) begin
               state_in = ST_REL_OUT;
            end
         end
         ST_REL_OUT: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_in.event_offset  = offset_ff;
               rsp_in.released_low  = held_ff[63:0];
               rsp_in.released_high = held_ff[127:64];
               rsp_in.emitted_count = count_ff[7:0];
               held_in              = '0;
               rp_in                = wp_ff;
               pending_in           = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         ST_CNT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ff;
            state_in    = ST_CNT_EV;
         end
         ST_CNT_EV: begin
            // count pass runs on a scratch copy so the real map is untouched
            if (ram_rd_data.note_on != scratch_ff[ram_rd_data.note]) begin
               scratch_in[ram_rd_data.note] = ram_rd_data.note_on;
               count_in = CNT_W'(count_ff + 1'b1);
            end
            scan_in = scan_next;
            if (scan_next == wp_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_CNT_RD;
            end
         end
         ST_EMIT_RD: begin
            if (rp_ff == wp_ff) begin
               if (count_ff == '0) begin
                  // everything was dropped: one empty response
                  if (out_free) begin
                     rsp_load            = 1'b1;
                     rsp_in.event_offset = offset_ff;
                     state_in            = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rp_ff;
               state_in    = ST_EMIT_EV;
            end
         end
         ST_EMIT_EV: begin
            if (ram_rd_data.note_on == held_ff[ram_rd_data.note]) begin
               rp_in    = next_ptr(rp_ff);
               state_in = ST_EMIT_RD;
            end else if (out_free) begin
               rsp_load             = 1'b1;
               rsp_in.message_valid = 1'b1;
               rsp_in.status_byte   = ram_rd_data.note_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
               rsp_in.note_out      = ram_rd_data.note;
               rsp_in.velocity_out  = ram_rd_data.note_on ? ram_rd_data.velocity : 7'd0;
               rsp_in.event_offset  = offset_ff;
               rsp_in.emitted_count = count_ff[7:0];
               rsp_in.last          = (CNT_W'(emit_ff + 1'b1) == count_ff);
               held_in[ram_rd_data.note] = ram_rd_data.note_on;
               emit_in  = CNT_W'(emit_ff + 1'b1);
               rp_in    = next_ptr(rp_ff);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         pending_ff   <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      scratch_ff <= scratch_in;
      count_ff   <= count_in;
      emit_ff    <= emit_in;
      chunk_ff   <= chunk_in;
      offset_ff  <= offset_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the count in every non-message response matches the masks it carries
   a_count_vs_masks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.message_valid) |->
      (32'(rsp_ff.emitted_count) ==
       32'($countones({rsp_ff.released_high, rsp_ff.released_low}))))
      else $error("release count does not match masks");

   // an emitted message always carries a nonzero total and a note-on or note-off status byte
   a_msg_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.message_valid) |->
      (rsp_ff.emitted_count != 8'd0 &&
       (rsp_ff.status_byte == STATUS_NOTE_ON || rsp_ff.status_byte == STATUS_NOTE_OFF)))
      else $error("bad emitted message");

   // clear empties the map, the flag and the queue
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.operation == OP_CLEAR) |=>
      (held_ff == '0 && !pending_ff && rp_ff == wp_ff))
      else $error("clear left state behind");

   // a render sequence ends with the queue drained
   a_render_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_in == ST_IDLE) |=> (rp_ff == wp_ff))
      else $error("render finished with commands left");

endmodule

`default_nettype wire

// ===== rtl/nedq_ring.sv =====
// nedq_ring: command store of the note event queue
// one write port and one read port with registered read data; uses nedq_pkg
`default_nettype none

module nedq_ring import nedq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire cmd_type                  wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output cmd_type                       rd_data
);

   cmd_type mem [DEPTH];
   cmd_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
